@@ design/gist_pkg.sv @@
// shared types and constants for the grey image statistics / isodata threshold block
// no dependencies; imported by every module of the block
`default_nettype none

package gist_pkg;

    localparam int NBINS   = 256;
    localparam int BIN_W   = 8;
    localparam int CNT_W   = 21;
    localparam int SUM_W   = 29;
    localparam int Q_W     = 16;
    localparam int DVD_W   = SUM_W + 8;
    localparam int STEP_W  = $clog2(Q_W);
    localparam int MED_W   = 9;
    localparam int ITER_W  = 8;
    localparam int CNT_MAX = 2097151;

    localparam logic [ITER_W-1:0] ITER_RESET = 8'd200;
    localparam logic [BIN_W-1:0]  PIX_ON     = 8'd255;
    localparam logic [BIN_W-1:0]  PIX_OFF    = 8'd0;
    localparam logic [BIN_W-1:0]  BIN_LAST   = 8'd255;

    localparam logic [1:0] REQ_ACC  = 2'd0;
    localparam logic [1:0] REQ_BIN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] KIND_STATS = 2'd0;
    localparam logic [1:0] KIND_BIN   = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    typedef enum logic [1:0] {
        DIV_MEAN  = 2'd0,
        DIV_ABOVE = 2'd1,
        DIV_BELOW = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [BIN_W-1:0] pixel;
        logic             frame_last;
        logic [BIN_W-1:0] bin_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [CNT_W-1:0]  pixel_count;
        logic [Q_W-1:0]    mean_q8;
        logic [MED_W-1:0]  median_x2;
        logic [Q_W-1:0]    threshold_q8;
        logic [ITER_W-1:0] iterations_used;
        logic              converged;
        logic [BIN_W-1:0]  binary_pixel;
        logic [CNT_W-1:0]  bin_count;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic     acc_start;
        logic     acc_write;
        logic     out_bin;
        logic     out_rd;
        logic     out_stats;
        logic     div_start;
        t_div_sel div_sel;
        logic     walk_start;
        logic     med_mode;
        logic     thr_mode;
        logic     t_upd;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic walk_done;
        logic left_zero;
        logic t_eq;
    } t_stat;

endpackage

`default_nettype wire

@@ design/gist_div.sv @@
// restoring divider, one quotient bit per cycle, 16-bit quotient
// uses gist_pkg; caller guarantees the quotient fits in 16 bits
`default_nettype none

module gist_div import gist_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_low;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_low[Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(Q_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // high part starts below the divisor, so the remainder stays in CNT_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:Q_W];
            r_low <= i_dividend[Q_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_low <= {r_low[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

`default_nettype wire

@@ design/gist_dp.sv @@
// datapath: histogram memory, frame totals, bin walk, threshold refinement, result register
// uses gist_pkg and gist_div; driven by gist_ctrl through t_cmd / t_stat
`default_nettype none

module gist_dp import gist_pkg::*; #(
    parameter int unsigned MAX_PIXELS = 1048576
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_req              i_req,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cfg_valid,
    input  wire logic [ITER_W-1:0] i_cfg_data,
    output t_stat                  o_stat,
    output logic                   o_res_valid,
    output t_res                   o_res
);

    localparam logic [CNT_W-1:0] CountCap =
        CNT_W'((MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX);

    logic [CNT_W-1:0]  r_mem [NBINS];
    logic [NBINS-1:0]  r_vld;
    logic [CNT_W-1:0]  r_q;
    logic              r_qv;

    logic [CNT_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sum;
    logic              r_frame_done;
    logic              r_inc;
    logic [BIN_W-1:0]  r_pix;
    logic [Q_W-1:0]    r_thold;
    logic [ITER_W-1:0] r_max_iter;

    logic              r_walking;
    logic [BIN_W-1:0]  r_addr;
    logic              r_wv;
    logic [BIN_W-1:0]  r_wbin;

    logic [CNT_W-1:0]  r_cum;
    logic              r_f1;
    logic              r_f2;
    logic [BIN_W-1:0]  r_l1;
    logic [BIN_W-1:0]  r_l2;
    logic [CNT_W-1:0]  r_na;
    logic [SUM_W-1:0]  r_sa;

    t_div_sel          r_div_sel;
    logic [Q_W-1:0]    r_mean;
    logic [Q_W-1:0]    r_ma;
    logic [Q_W-1:0]    r_mb;
    logic [Q_W-1:0]    r_t;
    logic [ITER_W-1:0] r_left;
    logic [ITER_W-1:0] r_iters;
    logic              r_conv;

    logic              r_out_vld;
    t_res              r_res;
    t_res              n_res;

    logic              w_clr;
    logic [CNT_W-1:0]  w_eff_total;
    logic              w_inc;
    logic [BIN_W-1:0]  w_rd_addr;
    logic [CNT_W-1:0]  w_h;
    logic [CNT_W-1:0]  w_cum_n;
    logic [CNT_W-1:0]  w_pos1;
    logic [CNT_W-1:0]  w_pos2;
    logic [SUM_W-1:0]  w_prod;
    logic              w_above;
    logic [CNT_W-1:0]  w_nb;
    logic [SUM_W-1:0]  w_sb;
    logic [DVD_W-1:0]  w_dvd;
    logic [CNT_W-1:0]  w_dvs;
    logic              w_div_done;
    logic [Q_W-1:0]    w_quot;
    logic [Q_W:0]      w_tsum;
    logic [Q_W-1:0]    w_nt;
    logic [MED_W-1:0]  w_med;

    // first pixel after a finished frame starts a fresh histogram
    assign w_clr       = i_cmd.acc_start && r_frame_done;
    assign w_eff_total = r_frame_done ? '0 : r_total;
    assign w_inc       = w_eff_total < CountCap;
    assign w_rd_addr   = r_walking ? r_addr :
                         ((i_req.req_type == REQ_READ) ? i_req.bin_index : i_req.pixel);
    assign w_h         = r_qv ? r_q : '0;

    always_ff @(posedge i_clk) begin
        r_q  <= r_mem[w_rd_addr];
        r_qv <= r_vld[w_rd_addr] && !w_clr;
        if (i_cmd.acc_write && r_inc) begin
            r_mem[r_pix] <= w_h + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_vld <= '0;
        end else if (i_cmd.acc_write && r_inc) begin
            r_vld[r_pix] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_sum        <= '0;
            r_frame_done <= 1'b0;
            r_thold      <= '0;
            r_max_iter   <= ITER_RESET;
            r_inc        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_iter <= i_cfg_data;
            end
            if (i_cmd.acc_start) begin
                r_frame_done <= 1'b0;
                r_inc        <= w_inc;
                r_total      <= w_eff_total + CNT_W'(w_inc);
                r_sum        <= (r_frame_done ? '0 : r_sum) +
                                (w_inc ? SUM_W'(i_req.pixel) : '0);
            end
            if (i_cmd.out_stats) begin
                r_frame_done <= 1'b1;
                r_thold      <= r_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_start) begin
            r_pix <= i_req.pixel;
        end
    end

    // bin walk: one address per cycle, data tagged with its bin in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_wv      <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_wv <= r_walking;
            if (i_cmd.walk_start) begin
                r_walking <= 1'b1;
                r_addr    <= '0;
            end else if (r_walking) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == BIN_LAST) begin
                    r_walking <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wbin <= r_addr;
    end

    assign w_pos2  = r_total >> 1;
    assign w_pos1  = r_total[0] ? w_pos2 : (w_pos2 - 1'b1);
    assign w_cum_n = r_cum + w_h;
    assign w_prod  = SUM_W'(r_wbin) * SUM_W'(w_h);
    assign w_above = {r_wbin, 8'h00} >= r_t;

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_cum <= '0;
            r_f1  <= 1'b0;
            r_f2  <= 1'b0;
            r_na  <= '0;
            r_sa  <= '0;
        end else if (r_wv) begin
            if (i_cmd.med_mode) begin
                r_cum <= w_cum_n;
                if (!r_f1 && (w_cum_n > w_pos1)) begin
                    r_f1 <= 1'b1;
                    r_l1 <= r_wbin;
                end
                if (!r_f2 && (w_cum_n > w_pos2)) begin
                    r_f2 <= 1'b1;
                    r_l2 <= r_wbin;
                end
            end
            if (i_cmd.thr_mode && w_above) begin
                r_na <= r_na + w_h;
                r_sa <= r_sa + w_prod;
            end
        end
    end

    // below side follows from the frame totals
    assign w_nb = r_total - r_na;
    assign w_sb = r_sum - r_sa;

    always_comb begin
        w_dvd = {r_sum, 8'h00};
        w_dvs = (r_total == '0) ? CNT_W'(1) : r_total;
        case (i_cmd.div_sel)
            DIV_ABOVE: begin
                w_dvd = {r_sa, 8'h00};
                w_dvs = (r_na == '0) ? CNT_W'(1) : r_na;
            end
            DIV_BELOW: begin
                w_dvd = {w_sb, 8'h00};
                w_dvs = (w_nb == '0) ? CNT_W'(1) : w_nb;
            end
            default: begin
                w_dvd = {r_sum, 8'h00};
                w_dvs = (r_total == '0) ? CNT_W'(1) : r_total;
            end
        endcase
    end

    gist_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_tsum = {1'b0, r_ma} + {1'b0, r_mb};
    assign w_nt   = w_tsum[Q_W:1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            case (r_div_sel)
                DIV_ABOVE: r_ma <= w_quot;
                DIV_BELOW: r_mb <= w_quot;
                default: begin
                    r_mean  <= w_quot;
                    r_t     <= w_quot;
                    r_left  <= r_max_iter;
                    r_iters <= '0;
                    r_conv  <= 1'b0;
                end
            endcase
        end else if (i_cmd.t_upd) begin
            r_iters <= r_iters + 1'b1;
            if (w_nt == r_t) begin
                r_conv <= 1'b1;
            end else begin
                r_left <= r_left - 1'b1;
                r_t    <= w_nt;
            end
        end
    end

    assign w_med = (r_total == '0) ? '0 : ({1'b0, r_l1} + {1'b0, r_l2});

    always_comb begin
        n_res = '0;
        if (i_cmd.out_stats) begin
            n_res.result_kind     = KIND_STATS;
            n_res.pixel_count     = r_total;
            n_res.mean_q8         = r_mean;
            n_res.median_x2       = w_med;
            n_res.threshold_q8    = r_t;
            n_res.iterations_used = r_iters;
            n_res.converged       = r_conv;
        end else if (i_cmd.out_rd) begin
            n_res.result_kind = KIND_COUNT;
            n_res.bin_count   = w_h;
        end else begin
            n_res.result_kind  = KIND_BIN;
            n_res.binary_pixel = (i_req.pixel > r_thold[Q_W-1:8]) ? PIX_ON : PIX_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.out_stats || i_cmd.out_rd || i_cmd.out_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.walk_done = r_wv && (r_wbin == BIN_LAST);
    assign o_stat.left_zero = r_left == '0;
    assign o_stat.t_eq      = w_nt == r_t;
    assign o_res_valid      = r_out_vld;
    assign o_res            = r_res;

endmodule

`default_nettype wire

@@ design/gist_ctrl.sv @@
// controller state machine sequencing accumulate, binarize, reads and end-of-frame statistics
// uses gist_pkg; drives gist_dp through t_cmd and watches t_stat
`default_nettype none

module gist_ctrl import gist_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_req  i_req,
    input  wire t_stat i_stat,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_ACC_WR    = 16'h0002,
        S_RD        = 16'h0004,
        S_MEAN_GO   = 16'h0008,
        S_MEAN_WAIT = 16'h0010,
        S_MED_GO    = 16'h0020,
        S_MED       = 16'h0040,
        S_ICHK      = 16'h0080,
        S_TW_GO     = 16'h0100,
        S_TW        = 16'h0200,
        S_DA_GO     = 16'h0400,
        S_DA_WAIT   = 16'h0800,
        S_DB_GO     = 16'h1000,
        S_DB_WAIT   = 16'h2000,
        S_TUPD      = 16'h4000,
        S_DONE      = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_MEAN;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_ACC: begin
                            o_cmd.acc_start = 1'b1;
                            n_state = S_ACC_WR;
                        end
                        REQ_BIN:  o_cmd.out_bin = 1'b1;
                        REQ_READ: n_state = S_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ACC_WR: begin
                o_cmd.acc_write = 1'b1;
                n_state = r_last ? S_MEAN_GO : S_IDLE;
            end
            S_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_IDLE;
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MED_GO;
                end
            end
            S_MED_GO: begin
                o_cmd.walk_start = 1'b1;
                n_state = S_MED;
            end
            S_MED: begin
                o_cmd.med_mode = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_ICHK;
                end
            end
            S_ICHK: begin
                n_state = i_stat.left_zero ? S_DONE : S_TW_GO;
            end
            S_TW_GO: begin
                o_cmd.walk_start = 1'b1;
                n_state = S_TW;
            end
            S_TW: begin
                o_cmd.thr_mode = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DA_GO;
                end
            end
            S_DA_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ABOVE;
                n_state = S_DA_WAIT;
            end
            S_DA_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DB_GO;
                end
            end
            S_DB_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_BELOW;
                n_state = S_DB_WAIT;
            end
            S_DB_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_TUPD;
                end
            end
            S_TUPD: begin
                o_cmd.t_upd = 1'b1;
                n_state = i_stat.t_eq ? S_DONE : S_ICHK;
            end
            S_DONE: begin
                o_cmd.out_stats = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_last <= i_req.frame_last;
            end
        end
    end

    assign o_busy = r_state != S_IDLE;

`ifndef SYNTHESIS
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_MEAN_WAIT || r_state == S_DA_WAIT ||
                             r_state == S_DB_WAIT))
        else $error("divider finished outside a wait state");
    a_walk_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.walk_done |-> (r_state == S_MED || r_state == S_TW))
        else $error("bin walk finished outside a walk state");
    a_acc_goes_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_ACC) |=> (r_state == S_ACC_WR))
        else $error("accumulate item not followed by its write cycle");
`endif

endmodule

`default_nettype wire

@@ design/grey_image_stats_isodata_threshold_top.sv @@
// binarize: result the cycle after accept, one item per cycle while not busy; bin read:
// memory read, then registered result; accumulate: bin read, then write, busy in write;
// end of frame: mean division, median walk, then per iteration a threshold walk and two
// divisions; 256-bin memory walks (one bin a cycle), shared divider; no result stall
// synchronous active-low reset clears the histogram valid bits, totals and threshold
// uses gist_pkg, gist_ctrl, gist_dp (with gist_div)
`default_nettype none

module grey_image_stats_isodata_threshold_top import gist_pkg::*; #(
    parameter int unsigned MAX_PIXELS = 1048576
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request item
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_req              i_req,
    // result item, one-cycle strobe, no backpressure
    output logic                   o_res_valid,
    output t_res                   o_res,
    // max iterations register
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [ITER_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // register writes are to be issued only while idle (the block does not enforce it); they are always taken
    assign o_cfg_ready = 1'b1;

    // controller: sequencing of item kinds and the end-of-frame passes
    gist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .i_stat  (w_stat),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    // datapath: histogram, totals, median and threshold arithmetic, result register
    gist_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for grey_image_stats_isodata_threshold_top: histogram, stats, threshold
// depends on gist_pkg and the block rtl; self-checking against an in-bench predictor
`default_nettype none

module tb;
    import gist_pkg::*;

    localparam int unsigned MAX_PIX_CAP = 1048576;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    t_req              i_req = '0;
    logic              i_cfg_valid = 1'b0;
    logic [ITER_W-1:0] i_cfg_data = '0;
    logic              o_busy;
    logic              o_res_valid;
    t_res              o_res;
    logic              o_cfg_ready;

    grey_image_stats_isodata_threshold_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state, mirrors the block registers
    int unsigned       hist_bins [NBINS];
    int unsigned       px_total;
    int unsigned       level_sum;
    logic [Q_W-1:0]    kept_thr;
    bit                frame_closed;
    logic [ITER_W-1:0] iter_limit;

    t_res        pending_results[$];
    int          n_errors = 0;
    int          n_items = 0;
    int          n_frames = 0;
    int          n_results = 0;

    // grey level at a sorted position of the current histogram
    function automatic int unsigned level_at_rank(int unsigned rank);
        int unsigned cum;
        cum = 0;
        for (int v = 0; v < NBINS; v++) begin
            cum += hist_bins[v];
            if (cum > rank) return 32'(v);
        end
        return 32'(NBINS - 1);
    endfunction

    // end-of-frame statistics and isodata refinement
    function automatic t_res close_frame();
        t_res        r;
        longint unsigned sum_hi, sum_lo, cnt_hi, cnt_lo, mean_hi, mean_lo;
        int unsigned mean, med, thr, nthr, iters, left;
        bit          conv;
        r = '0;
        mean = 0;
        med = 0;
        iters = 0;
        conv = 0;
        if (px_total != 0) begin
            mean = 32'((longint'(level_sum) << 8) / px_total);
            if (px_total % 2 == 0)
                med = level_at_rank(px_total / 2 - 1) + level_at_rank(px_total / 2);
            else
                med = 2 * level_at_rank(px_total / 2);
        end
        thr = mean;
        left = 32'(iter_limit);
        while (left != 0) begin
            sum_hi = 0; sum_lo = 0; cnt_hi = 0; cnt_lo = 0;
            for (int v = 0; v < NBINS; v++) begin
                if ((longint'(v) << 8) >= thr) begin
                    sum_hi += longint'(v) * hist_bins[v];
                    cnt_hi += hist_bins[v];
                end else begin
                    sum_lo += longint'(v) * hist_bins[v];
                    cnt_lo += hist_bins[v];
                end
            end
            // an empty side counts as one pixel of level zero
            if (cnt_hi == 0) cnt_hi = 1;
            if (cnt_lo == 0) cnt_lo = 1;
            mean_hi = (sum_hi << 8) / cnt_hi;
            mean_lo = (sum_lo << 8) / cnt_lo;
            nthr = 32'(((mean_hi + mean_lo) / 2) & 16'hFFFF);
            iters++;
            if (nthr == thr) begin
                conv = 1;
                break;
            end
            left--;
            thr = nthr;
        end
        kept_thr = thr[Q_W-1:0];
        frame_closed = 1;
        r.result_kind     = KIND_STATS;
        r.pixel_count     = px_total[CNT_W-1:0];
        r.mean_q8         = mean[Q_W-1:0];
        r.median_x2       = med[MED_W-1:0];
        r.threshold_q8    = kept_thr;
        r.iterations_used = iters[ITER_W-1:0];
        r.converged       = conv;
        return r;
    endfunction

    // apply one accepted request to the predictor, queue any result
    function automatic void predict_request(t_req q);
        t_res r;
        r = '0;
        case (q.req_type)
            REQ_ACC: begin
                if (frame_closed) begin
                    foreach (hist_bins[i]) hist_bins[i] = 0;
                    px_total = 0;
                    level_sum = 0;
                    frame_closed = 0;
                end
                if (px_total < MAX_PIX_CAP) begin
                    hist_bins[q.pixel]++;
                    px_total++;
                    level_sum += 32'(q.pixel);
                end
                if (q.frame_last) begin
                    pending_results.push_back(close_frame());
                    n_frames++;
                end
            end
            REQ_BIN: begin
                r.result_kind  = KIND_BIN;
                r.binary_pixel = (q.pixel > kept_thr[Q_W-1:8]) ? PIX_ON : PIX_OFF;
                pending_results.push_back(r);
            end
            REQ_READ: begin
                r.result_kind = KIND_COUNT;
                r.bin_count   = hist_bins[q.bin_index][CNT_W-1:0];
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // compare every result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result %h", $time, o_res);
            end else begin
                want = pending_results.pop_front();
                if (want !== o_res) begin
                    n_errors++;
                    $display("%0t: mismatch kind exp %0d got %0d", $time,
                             want.result_kind, o_res.result_kind);
                    $display("  count exp %0d got %0d  mean exp %h got %h",
                             want.pixel_count, o_res.pixel_count, want.mean_q8, o_res.mean_q8);
                    $display("  median exp %0d got %0d  thr exp %h got %h",
                             want.median_x2, o_res.median_x2,
                             want.threshold_q8, o_res.threshold_q8);
                    $display("  iters exp %0d got %0d  conv exp %0d got %0d",
                             want.iterations_used, o_res.iterations_used,
                             want.converged, o_res.converged);
                    $display("  binary exp %0d got %0d  bin exp %0d got %0d",
                             want.binary_pixel, o_res.binary_pixel,
                             want.bin_count, o_res.bin_count);
                end
            end
        end
    end

    // drive one request, wait for accept, then a random gap
    task automatic send_request(t_req q, bit no_gap = 0);
        int gap;
        i_start <= 1'b1;
        i_req   <= q;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_request(q);
        n_items++;
        gap = no_gap ? 0 : 32'($urandom_range(0, 7));
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] kind, logic [7:0] pix, bit last, logic [7:0] idx);
        t_req q;
        q.req_type   = kind;
        q.pixel      = pix;
        q.frame_last = last;
        q.bin_index  = idx;
        send_request(q);
    endtask

    // stop requesting and let everything expected come out
    task automatic drain();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_iter_limit(logic [ITER_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        iter_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    // one frame: levels drawn by shape, 0 uniform, 1 two clusters, 2 flat
    task automatic send_frame(int len, int shape);
        logic [7:0] pix, lo_c, hi_c, flat;
        lo_c = 8'($urandom_range(0, 100));
        hi_c = 8'($urandom_range(140, 255));
        flat = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: pix = 8'($urandom);
                1: pix = 8'(($urandom_range(0, 1) ? hi_c : lo_c) +
                            $urandom_range(0, 15) - 8);
                default: pix = flat;
            endcase
            send_fields(REQ_ACC, pix, i == len - 1, 8'($urandom));
        end
    endtask

    task automatic test_after_reset();
        // kept threshold is zero: any nonzero level binarizes high
        send_fields(REQ_BIN, 8'd0, 1'b1, 8'hFF);
        send_fields(REQ_BIN, 8'd255, 1'b0, 8'h00);
        send_fields(REQ_READ, 8'hFF, 1'b1, 8'd0);
        send_fields(REQ_READ, 8'h00, 1'b0, 8'd255);
        send_fields(REQ_NONE, 8'hFF, 1'b1, 8'hFF);
        send_fields(REQ_NONE, 8'h00, 1'b0, 8'h00);
        drain();
    endtask

    task automatic test_directed_frames();
        // single dark pixel, then a bright pair, odd and even medians
        send_fields(REQ_ACC, 8'd0, 1'b1, 8'd0);
        send_fields(REQ_READ, 8'd0, 1'b0, 8'd0);
        send_fields(REQ_ACC, 8'd255, 1'b0, 8'd0);
        // partial count read mid frame
        send_fields(REQ_READ, 8'd0, 1'b0, 8'd255);
        send_fields(REQ_ACC, 8'd255, 1'b1, 8'd0);
        send_fields(REQ_BIN, 8'd255, 1'b0, 8'd0);
        send_fields(REQ_ACC, 8'd10, 1'b0, 8'd0);
        send_fields(REQ_ACC, 8'd200, 1'b0, 8'd0);
        send_fields(REQ_ACC, 8'd20, 1'b0, 8'd0);
        send_fields(REQ_ACC, 8'd210, 1'b1, 8'd0);
        send_fields(REQ_BIN, 8'd100, 1'b0, 8'd0);
        send_fields(REQ_BIN, 8'd150, 1'b0, 8'd0);
        send_fields(REQ_READ, 8'd0, 1'b0, 8'd200);
        drain();
    endtask

    task automatic test_iter_limits();
        logic [ITER_W-1:0] limits[4] = '{8'd0, 8'd1, 8'd255, ITER_RESET};
        foreach (limits[i]) begin
            write_iter_limit(limits[i]);
            send_frame(12, 1);
            send_fields(REQ_BIN, 8'd128, 1'b0, 8'd0);
        end
        drain();
    endtask

    task automatic test_random_traffic();
        int r, len;
        while (n_items < 1050) begin
            r = 32'($urandom_range(0, 99));
            if (r < 8) begin
                case ($urandom_range(0, 3))
                    0: write_iter_limit(8'd0);
                    1: write_iter_limit(8'd1);
                    2: write_iter_limit(8'd255);
                    default: write_iter_limit(8'($urandom));
                endcase
            end else if (r < 70) begin
                len = ($urandom_range(0, 19) == 0) ? 32'($urandom_range(100, 300))
                                                   : 32'($urandom_range(1, 24));
                send_frame(len, 32'($urandom_range(0, 2)));
            end else begin
                // loose traffic between frames, including requests mid frame
                send_fields(2'($urandom_range(0, 3)), 8'($urandom),
                            1'($urandom_range(0, 1)), 8'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        foreach (hist_bins[i]) hist_bins[i] = 0;
        px_total = 0;
        level_sum = 0;
        kept_thr = '0;
        frame_closed = 0;
        iter_limit = ITER_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_directed_frames();
        test_iter_limits();
        test_random_traffic();
        $display("covered %0d items, %0d frames, %0d results checked",
                 n_items, n_frames, n_results);
        if (n_errors == 0) begin
            $display("** grey_image_stats_isodata_threshold_top: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** grey_image_stats_isodata_threshold_top: FAILED **");
        end
        $finish;
    end

    // run limit, well above every item closing a frame at the full iteration count
    initial begin
        repeat (1000) #5000000;
        $display("timeout");
        $display("** grey_image_stats_isodata_threshold_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
